### rtl/wcts_pkg.sv
// -----------------------------------------------------------------------------
// wcts_pkg
// Shared types and constants for the wall column texture shader.
// -----------------------------------------------------------------------------
package wcts_pkg;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_BEGIN = 2'd1,
      CMD_DRAW  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic {
      REG_SCREEN_ROWS = 1'b0,
      REG_SHADE_BASE  = 1'b1
   } reg_type;

   localparam int STORE_AW = 12;
   localparam int ONE_Q16  = 65536;

   // shared divider: dividend up to 2^32, divisor below 2^26
   localparam int DIV_NW  = 33;
   localparam int DIV_DW  = 26;
   localparam int DIV_CW  = $clog2(DIV_NW + 1);

   localparam logic [10:0] SCREEN_ROWS_RST = 11'd240;
   localparam logic [23:0] SHADE_BASE_RST  = 24'd65536;

endpackage

### rtl/wcts_div.sv
// -----------------------------------------------------------------------------
// wcts_div
// Restoring unsigned divider, one quotient bit per cycle.
// -----------------------------------------------------------------------------
module wcts_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [wcts_pkg::DIV_NW-1:0]    dividend,
   input  logic [wcts_pkg::DIV_DW-1:0]    divisor,
   output logic                           done,
   output logic [wcts_pkg::DIV_NW-1:0]    quotient
);

   logic [wcts_pkg::DIV_DW-1:0] rem_ff;
   logic [wcts_pkg::DIV_NW-1:0] quo_ff;
   logic [wcts_pkg::DIV_DW-1:0] den_ff;
   logic [wcts_pkg::DIV_CW-1:0] cnt_ff;
   logic                        done_ff;
   logic [wcts_pkg::DIV_DW:0]   shifted;
   logic                        fits;

   assign shifted  = {rem_ff, quo_ff[wcts_pkg::DIV_NW-1]};
   assign fits     = shifted >= {1'b0, den_ff};
   assign done     = done_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            cnt_ff <= wcts_pkg::DIV_CW'(wcts_pkg::DIV_NW);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == wcts_pkg::DIV_CW'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         den_ff <= divisor;
      end else if (cnt_ff != '0) begin
         rem_ff <= fits ? wcts_pkg::DIV_DW'(shifted - {1'b0, den_ff})
                        : shifted[wcts_pkg::DIV_DW-1:0];
         quo_ff <= {quo_ff[wcts_pkg::DIV_NW-2:0], fits};
      end
   end

endmodule

### rtl/wall_column_texture_shader.sv
// Draw path: a draw item's pixel passes the memory read register, then the shading
//   multiply into the output register; a load writes the store when it is accepted.
// Throughput: loads and draws one item per cycle while the output is not stalled; a
//   begin-column item holds the port during two 33-step passes of the shared serial divider.
// Reset: synchronous; clears control state, registers return to 240 / 1.0.
// -----------------------------------------------------------------------------
// wall_column_texture_shader
// Texture store plus per-column setup and per-row shaded texel output.
// -----------------------------------------------------------------------------
module wall_column_texture_shader #(
   parameter int TEX_WIDTH  = 64,
   parameter int TEX_HEIGHT = 64,
   parameter int MAX_ROWS   = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [1:0]   req_cmd,
   input  logic [11:0]  req_texel_index,
   input  logic [31:0]  req_texel_color,
   input  logic [9:0]   req_top_row,
   input  logic [9:0]   req_bottom_row,
   input  logic [15:0]  req_wall_height,
   input  logic         req_hit_side,
   input  logic         req_dir_x_negative,
   input  logic         req_dir_y_positive,
   input  logic [15:0]  req_hit_fraction,
   input  logic [23:0]  req_hit_distance,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [9:0]   rsp_row,
   output logic [31:0]  rsp_pixel_color,
   output logic         rsp_last_row,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int COL_W  = $clog2(TEX_WIDTH);
   localparam int CP_W   = 16 + COL_W;
   localparam int TY_W   = $clog2(TEX_HEIGHT);
   localparam int STEP_W = $clog2(TEX_HEIGHT) + 17;
   localparam int NUM_W  = 19;
   localparam int PROD_W = NUM_W + STEP_W + 1;
   localparam int DEPTH  = 1 << wcts_pkg::STORE_AW;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHADE,
      ST_STEP,
      ST_MUL,
      ST_POS
   } state_type;

   // configuration
   logic [10:0] screen_rows_ff;
   logic [23:0] shade_base_ff;
   logic        cfg_wr;

   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_rows_ff <= wcts_pkg::SCREEN_ROWS_RST;
         shade_base_ff  <= wcts_pkg::SHADE_BASE_RST;
      end else if (cfg_wr) begin
         case (wcts_pkg::reg_type'(csr_paddr[2]))
            wcts_pkg::REG_SCREEN_ROWS: screen_rows_ff <= csr_pwdata[10:0];
            wcts_pkg::REG_SHADE_BASE:  shade_base_ff  <= csr_pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (wcts_pkg::reg_type'(csr_paddr[2]))
         wcts_pkg::REG_SCREEN_ROWS: csr_prdata = {21'd0, screen_rows_ff};
         wcts_pkg::REG_SHADE_BASE:  csr_prdata = {8'd0, shade_base_ff};
         default:                   csr_prdata = '0;
      endcase
   end

   // texture store
   logic [31:0] tex_mem [DEPTH];
   logic [31:0] mem_q_ff;

   // column state
   state_type                   state_ff;
   logic [COL_W-1:0]            column_ff;
   logic signed [31:0]          position_ff;
   logic [STEP_W-1:0]           step_ff;
   logic [16:0]                 shade_ff;
   logic [9:0]                  cur_row_ff;
   logic [9:0]                  end_row_ff;
   logic                        active_ff;
   logic signed [NUM_W-1:0]     num_ff;
   logic                        den_zero_ff;
   logic [15:0]                 height_ff;
   logic signed [PROD_W-1:0]    prod_ff;

   // draw pipeline
   logic        s1_valid_ff;
   logic [9:0]  s1_row_ff;
   logic        s1_last_ff;
   logic [16:0] s1_shade_ff;
   logic        out_valid_ff;
   logic [9:0]  out_row_ff;
   logic [31:0] out_color_ff;
   logic        out_last_ff;

   logic out_blocked;
   logic accept;
   logic is_load;
   logic is_begin;
   logic is_draw;
   logic draw_fire;
   logic s1_move;

   assign out_blocked = out_valid_ff & rsp_stall;
   assign req_stall   = (state_ff != ST_IDLE) | (s1_valid_ff & out_blocked);
   assign accept      = req_valid & ~req_stall;
   assign is_load     = wcts_pkg::cmd_type'(req_cmd) == wcts_pkg::CMD_LOAD;
   assign is_begin    = wcts_pkg::cmd_type'(req_cmd) == wcts_pkg::CMD_BEGIN;
   assign is_draw     = wcts_pkg::cmd_type'(req_cmd) == wcts_pkg::CMD_DRAW;
   assign draw_fire   = accept & is_draw & active_ff;
   assign s1_move     = s1_valid_ff & ~out_blocked;

   // texture row from position, truncated toward zero, wrapped once, clamped
   logic        pos_neg;
   logic [32:0] pos_mag;
   logic [16:0] ty_t;
   logic [16:0] ty_full;
   logic [TY_W-1:0] ty;
   logic [19:0] addr_full;

   always_comb begin
      pos_neg = position_ff[31];
      pos_mag = pos_neg ? 33'(-{position_ff[31], position_ff})
                        : {1'b0, position_ff};
      ty_t    = pos_mag[32:16];
      if (pos_neg && ty_t != '0) begin
         ty_full = (ty_t > 17'(TEX_HEIGHT)) ? 17'd0 : 17'(TEX_HEIGHT) - ty_t;
      end else begin
         ty_full = (ty_t >= 17'(TEX_HEIGHT)) ? 17'(TEX_HEIGHT - 1) : ty_t;
      end
      ty        = ty_full[TY_W-1:0];
      addr_full = 20'(ty) * 20'(TEX_WIDTH) + 20'(column_ff);
   end

   always_ff @(posedge clock) begin
      if (accept && is_load) begin
         tex_mem[req_texel_index] <= req_texel_color;
      end
      if (draw_fire) begin
         mem_q_ff <= tex_mem[addr_full[wcts_pkg::STORE_AW-1:0]];
      end
   end

   // column setup combinational pieces
   logic [CP_W-1:0]    col_prod;
   logic [COL_W-1:0]   col_raw;
   logic               mirror;
   logic [25:0]        shade_den;
   logic [15:0]        wh_fix;
   logic signed [NUM_W-1:0] num_in;
   logic [9:0]         bot_clamped;

   always_comb begin
      col_prod = CP_W'(req_hit_fraction) * CP_W'(TEX_WIDTH);
      col_raw  = (col_prod[CP_W-1:16] > COL_W'(TEX_WIDTH - 1)) ? COL_W'(TEX_WIDTH - 1)
                                                               : col_prod[CP_W-1:16];
      mirror   = (req_hit_side & req_dir_y_positive) |
                 (~req_hit_side & req_dir_x_negative);
      shade_den = 26'(shade_base_ff) + (req_hit_side ? 26'(wcts_pkg::ONE_Q16) : 26'd0)
                + 26'(req_hit_distance);
      wh_fix   = (req_wall_height == '0) ? 16'd1 : req_wall_height;
      num_in   = NUM_W'($signed({1'b0, req_top_row, 1'b0}))
               - NUM_W'($signed({1'b0, screen_rows_ff}))
               + NUM_W'($signed({1'b0, wh_fix}));
      bot_clamped = (13'(req_bottom_row) > 13'(MAX_ROWS - 1)) ? 10'(MAX_ROWS - 1)
                                                               : req_bottom_row;
   end

   // shared divider
   logic                        div_start;
   logic [wcts_pkg::DIV_NW-1:0] div_num;
   logic [wcts_pkg::DIV_DW-1:0] div_den;
   logic                        div_done;
   logic [wcts_pkg::DIV_NW-1:0] div_q;

   always_comb begin
      div_start = 1'b0;
      div_num   = {1'b1, 32'd0};
      div_den   = shade_den;
      if (accept && is_begin) begin
         div_start = 1'b1;
      end else if (state_ff == ST_SHADE && div_done) begin
         div_start = 1'b1;
         div_num   = wcts_pkg::DIV_NW'(TEX_HEIGHT) << 16;
         div_den   = wcts_pkg::DIV_DW'(height_ff);
      end
   end

   wcts_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   logic signed [PROD_W-1:0] half_prod;
   logic signed [32:0]       pos_next;

   assign half_prod = prod_ff >>> 1;
   assign pos_next  = 33'(position_ff) + 33'($signed({1'b0, step_ff}));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         active_ff   <= 1'b0;
         column_ff   <= '0;
         position_ff <= '0;
         step_ff     <= '0;
         shade_ff    <= '0;
         cur_row_ff  <= '0;
         end_row_ff  <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept && is_begin) begin
                  column_ff   <= mirror ? COL_W'(TEX_WIDTH - 1) - col_raw : col_raw;
                  den_zero_ff <= shade_den == '0;
                  height_ff   <= wh_fix;
                  num_ff      <= num_in;
                  cur_row_ff  <= req_top_row;
                  end_row_ff  <= bot_clamped;
                  active_ff   <= req_top_row <= bot_clamped;
                  state_ff    <= ST_SHADE;
               end else if (draw_fire) begin
                  // step is never negative, so only the upper bound can be crossed
                  position_ff <= (!pos_next[32] && pos_next[31]) ? 32'h7FFF_FFFF
                                                                 : pos_next[31:0];
                  if (cur_row_ff == end_row_ff) begin
                     active_ff <= 1'b0;
                  end else begin
                     cur_row_ff <= cur_row_ff + 1'b1;
                  end
               end
            end
            ST_SHADE: begin
               if (div_done) begin
                  if (den_zero_ff || div_q >= wcts_pkg::DIV_NW'(wcts_pkg::ONE_Q16)) begin
                     shade_ff <= 17'(wcts_pkg::ONE_Q16);
                  end else begin
                     shade_ff <= div_q[16:0];
                  end
                  state_ff <= ST_STEP;
               end
            end
            ST_STEP: begin
               if (div_done) begin
                  step_ff  <= div_q[STEP_W-1:0];
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               prod_ff  <= PROD_W'(num_ff) * PROD_W'($signed({1'b0, step_ff}));
               state_ff <= ST_POS;
            end
            ST_POS: begin
               if (half_prod > PROD_W'(64'sh7FFF_FFFF)) begin
                  position_ff <= 32'h7FFF_FFFF;
               end else if (half_prod < -PROD_W'(64'sh8000_0000)) begin
                  position_ff <= 32'h8000_0000;
               end else begin
                  position_ff <= half_prod[31:0];
               end
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // draw pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (draw_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   logic [24:0] prod_r;
   logic [24:0] prod_g;
   logic [24:0] prod_b;

   assign prod_r = 25'(mem_q_ff[23:16]) * 25'(s1_shade_ff);
   assign prod_g = 25'(mem_q_ff[15:8])  * 25'(s1_shade_ff);
   assign prod_b = 25'(mem_q_ff[7:0])   * 25'(s1_shade_ff);

   always_ff @(posedge clock) begin
      if (draw_fire) begin
         s1_row_ff   <= cur_row_ff;
         s1_last_ff  <= cur_row_ff == end_row_ff;
         s1_shade_ff <= shade_ff;
      end
      if (s1_move) begin
         out_row_ff   <= s1_row_ff;
         out_last_ff  <= s1_last_ff;
         out_color_ff <= {mem_q_ff[31:24], prod_r[23:16], prod_g[23:16], prod_b[23:16]};
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_row         = out_row_ff;
   assign rsp_pixel_color = out_color_ff;
   assign rsp_last_row    = out_last_ff;

`ifndef ASSERT_OFF
   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> req_stall)
      else $error("input taken during column setup");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_SHADE || state_ff == ST_STEP))
      else $error("divider finished outside setup");

   a_s1_held: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && out_blocked |=> s1_valid_ff && $stable(s1_row_ff))
      else $error("pending pixel lost while output stalled");

   a_draw_needs_column: assert property (@(posedge clock) disable iff (reset)
      draw_fire |-> state_ff == ST_IDLE && active_ff)
      else $error("row issued without open column");
`endif

endmodule
